@@ design/multilead_cascaded_moving_average_top_defines.svh @@
// ----------------------------------------------------------------------------
// multilead cascaded moving average - assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef MULTILEAD_CASCADED_MOVING_AVERAGE_TOP_DEFINES_SVH
`define MULTILEAD_CASCADED_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication
`define MCMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mcma_pkg.sv @@
// ----------------------------------------------------------------------------
// mcma_pkg
// shared constants, codes and types of the multi-lead moving average filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mcma_pkg;

  localparam int LEADS      = 8;
  localparam int LOW_DEPTH  = 8;
  localparam int HIGH_DEPTH = 1024;

  localparam int SAMPLE_W = 24;
  localparam int LEAD_W   = 3;
  localparam int OUT_W    = 25;
  localparam int LPOS_W   = $clog2(LOW_DEPTH);
  localparam int HPOS_W   = $clog2(HIGH_DEPTH);
  localparam int KLEN_W   = 4;
  localparam int LLEN_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam int LRS_W = 27;
  localparam int LDS_W = 30;
  localparam int HRS_W = 34;
  localparam int HDS_W = 44;
  localparam int DVD_W = HDS_W;
  localparam int DVS_W = 2 * HPOS_W + 1;

  localparam int LRAM_D = LEADS * LOW_DEPTH;
  localparam int HRAM_D = LEADS * HIGH_DEPTH;
  localparam int CLR_W  = $clog2(HRAM_D);

  localparam logic [1:0] MODE_LOW  = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_BAND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEN = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [LEAD_W-1:0]   lead;
    logic [LPOS_W-1:0]   lpos;
    logic [HPOS_W-1:0]   hpos;
    logic                do_low;
    logic                do_high;
    logic                in_range;
    logic [KLEN_W-1:0]   klen;
    logic [LLEN_W-1:0]   llen;
  } mcma_item_t;

endpackage

@@ design/mcma_ram.sv @@
// ----------------------------------------------------------------------------
// mcma_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mcma_div.sv @@
// ----------------------------------------------------------------------------
// mcma_div
// bit-serial signed divider, quotient truncated toward zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcma_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mcma_pkg::DVD_W-1:0] dividend,
  input  logic [mcma_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [mcma_pkg::DVD_W-1:0] quotient
);
  import mcma_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic                busy_r;
  logic                done_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DVD_W-1:0]    mag_r;
  logic [DVS_W-1:0]    rem_r;
  logic [DVS_W-1:0]    div_r;
  logic [DVS_W:0]      trial;
  logic                ge;

  assign trial = {rem_r, mag_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[DVD_W-1];
        mag_r  <= dividend[DVD_W-1] ? -dividend : dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DVS_W'(trial - {1'b0, div_r}) : trial[DVS_W-1:0];
        mag_r <= {mag_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -mag_r : mag_r;

endmodule

@@ design/mcma_front.sv @@
// ----------------------------------------------------------------------------
// mcma_front
// accepts samples, holds configuration and ring positions, queues items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcma_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mcma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [mcma_pkg::LEAD_W-1:0]    in_lead,
  input  logic                           cfg_we,
  input  logic [mcma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcma_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           clear_busy,
  input  logic                           pop,
  output logic                           head_valid,
  output mcma_pkg::mcma_item_t           head
);
  import mcma_pkg::*;

  logic [1:0]        mode_r;
  logic [KLEN_W-1:0] low_len_r;
  logic [LLEN_W-1:0] high_len_r;
  logic [LPOS_W-1:0] lpos_r;
  logic [HPOS_W-1:0] hpos_r;
  mcma_item_t        q_mem [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;

  logic [KLEN_W-1:0] klen;
  logic [LLEN_W-1:0] llen;
  logic [LPOS_W-1:0] lpos_sel;
  logic [HPOS_W-1:0] hpos_sel;
  logic [LPOS_W:0]   lpos_inc;
  logic [HPOS_W:0]   hpos_inc;
  logic              accept;
  mcma_item_t        item;

  always_comb begin
    if (low_len_r == '0) begin
      klen = KLEN_W'(1);
    end else if (low_len_r > KLEN_W'(LOW_DEPTH)) begin
      klen = KLEN_W'(LOW_DEPTH);
    end else begin
      klen = low_len_r;
    end
    if (high_len_r == '0) begin
      llen = LLEN_W'(1);
    end else if (high_len_r > LLEN_W'(HIGH_DEPTH)) begin
      llen = LLEN_W'(HIGH_DEPTH);
    end else begin
      llen = high_len_r;
    end
  end

  assign lpos_sel = (KLEN_W'({1'b0, lpos_r}) < klen) ? lpos_r : '0;
  assign hpos_sel = (LLEN_W'({1'b0, hpos_r}) < llen) ? hpos_r : '0;
  assign lpos_inc = {1'b0, lpos_sel} + 1'b1;
  assign hpos_inc = {1'b0, hpos_sel} + 1'b1;

  assign in_stall = clear_busy | (cnt_r == 2'd2);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    item.sample   = in_sample;
    item.lead     = in_lead;
    item.lpos     = lpos_sel;
    item.hpos     = hpos_sel;
    item.do_low   = (mode_r != MODE_HIGH);
    item.do_high  = (mode_r != MODE_LOW);
    item.in_range = ({1'b0, in_lead} < (LEAD_W + 1)'(LEADS));
    item.klen     = klen;
    item.llen     = llen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BAND;
      low_len_r  <= KLEN_W'(4);
      high_len_r <= LLEN_W'(410);
      lpos_r     <= '0;
      hpos_r     <= '0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:     mode_r     <= cfg_wdata[1:0];
          CFG_LOW_LEN:  low_len_r  <= cfg_wdata[KLEN_W-1:0];
          CFG_HIGH_LEN: high_len_r <= cfg_wdata[LLEN_W-1:0];
          default:      ;
        endcase
      end
      if (accept) begin
        wr_ptr_r <= ~wr_ptr_r;
        if (item.in_range && in_lead == LEAD_W'(LEADS - 1)) begin
          lpos_r <= (KLEN_W'(lpos_inc) >= klen) ? '0 : lpos_inc[LPOS_W-1:0];
          hpos_r <= (LLEN_W'(hpos_inc) >= llen) ? '0 : hpos_inc[HPOS_W-1:0];
        end
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr_r] <= item;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = q_mem[rd_ptr_r];

endmodule

@@ design/mcma_back.sv @@
// ----------------------------------------------------------------------------
// mcma_back
// per-item sequencer: ring access, running sums, division, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcma_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  mcma_pkg::mcma_item_t        head,
  output logic                        pop,
  output logic                        clear_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcma_pkg::OUT_W-1:0]  out_filtered
);
  import mcma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_LOW, S_LDIV, S_HIGH, S_HDIV, S_DONE
  } state_t;

  localparam int LA_W = $clog2(LRAM_D);
  localparam int HA_W = $clog2(HRAM_D);

  state_t              state_r;
  mcma_item_t          item_r;
  logic [LRS_W-1:0]    lrs_r [LEADS];
  logic [LDS_W-1:0]    lds_r [LEADS];
  logic [HRS_W-1:0]    hrs_r [LEADS];
  logic [HDS_W-1:0]    hds_r [LEADS];
  logic [SAMPLE_W-1:0] cur_r;
  logic [SAMPLE_W-1:0] delayed_r;
  logic [OUT_W-1:0]    res_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_filtered_r;
  logic [CLR_W-1:0]    clr_cnt_r;
  logic                clr_act_r;

  logic [LA_W-1:0]     laddr;
  logic [HA_W-1:0]     haddr;
  logic [SAMPLE_W-1:0] lsmp_rd, hsmp_rd;
  logic [LRS_W-1:0]    lsum_rd;
  logic [HRS_W-1:0]    hsum_rd;
  logic [LRS_W-1:0]    sp_l;
  logic [LDS_W-1:0]    st_l;
  logic [HRS_W-1:0]    sp_h;
  logic [HDS_W-1:0]    st_h;
  logic                low_go, high_go;
  logic                lwe, hwe;
  logic [LA_W-1:0]     lwaddr;
  logic [HA_W-1:0]     hwaddr;
  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dvd, div_q;
  logic [DVS_W-1:0]    div_dvs;
  logic [2*KLEN_W-1:0] kk;
  logic [2*LLEN_W-1:0] ll;
  logic                out_load;

  assign laddr = {item_r.lead, item_r.lpos};
  assign haddr = {item_r.lead, item_r.hpos};

  assign sp_l = lrs_r[item_r.lead] + LRS_W'($signed(item_r.sample))
              - LRS_W'($signed(lsmp_rd));
  assign st_l = lds_r[item_r.lead] + LDS_W'($signed(sp_l)) - LDS_W'($signed(lsum_rd));
  assign sp_h = hrs_r[item_r.lead] + HRS_W'($signed(cur_r)) - HRS_W'($signed(hsmp_rd));
  assign st_h = hds_r[item_r.lead] + HDS_W'($signed(sp_h)) - HDS_W'($signed(hsum_rd));

  assign low_go  = (state_r == S_LOW) && item_r.in_range && item_r.do_low;
  assign high_go = (state_r == S_HIGH) && item_r.do_high;

  assign lwe    = clr_act_r | low_go;
  assign hwe    = clr_act_r | high_go;
  assign lwaddr = clr_act_r ? clr_cnt_r[LA_W-1:0] : laddr;
  assign hwaddr = clr_act_r ? clr_cnt_r[HA_W-1:0] : haddr;

  assign kk        = item_r.klen * item_r.klen;
  assign ll        = item_r.llen * item_r.llen;
  assign div_start = low_go | high_go;
  assign div_dvd   = low_go ? DVD_W'($signed(st_l)) : st_h;
  assign div_dvs   = low_go ? DVS_W'(kk) : ll[DVS_W-1:0];

  assign pop      = (state_r == S_IDLE) && head_valid && !clr_act_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  mcma_ram #(.WIDTH(SAMPLE_W), .DEPTH(LRAM_D)) u_low_smp (
    .clk(clk), .we(lwe), .waddr(lwaddr),
    .wdata(clr_act_r ? '0 : item_r.sample), .raddr(laddr), .rdata(lsmp_rd)
  );

  mcma_ram #(.WIDTH(LRS_W), .DEPTH(LRAM_D)) u_low_sum (
    .clk(clk), .we(lwe), .waddr(lwaddr),
    .wdata(clr_act_r ? '0 : sp_l), .raddr(laddr), .rdata(lsum_rd)
  );

  mcma_ram #(.WIDTH(SAMPLE_W), .DEPTH(HRAM_D)) u_high_smp (
    .clk(clk), .we(hwe), .waddr(hwaddr),
    .wdata(clr_act_r ? '0 : cur_r), .raddr(haddr), .rdata(hsmp_rd)
  );

  mcma_ram #(.WIDTH(HRS_W), .DEPTH(HRAM_D)) u_high_sum (
    .clk(clk), .we(hwe), .waddr(hwaddr),
    .wdata(clr_act_r ? '0 : sp_h), .raddr(haddr), .rdata(hsum_rd)
  );

  mcma_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      clr_act_r   <= 1'b1;
      for (int i = 0; i < LEADS; i++) begin
        lrs_r[i] <= '0;
        lds_r[i] <= '0;
        hrs_r[i] <= '0;
        hds_r[i] <= '0;
      end
    end else begin
      if (clr_act_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(HRAM_D - 1)) begin
          clr_act_r <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_r    <= 1'b1;
        out_filtered_r <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            item_r  <= head;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LOW;
        S_LOW: begin
          if (!item_r.in_range) begin
            res_r   <= '0;
            state_r <= S_DONE;
          end else if (item_r.do_low) begin
            lrs_r[item_r.lead] <= sp_l;
            lds_r[item_r.lead] <= st_l;
            state_r            <= S_LDIV;
          end else begin
            cur_r   <= item_r.sample;
            state_r <= S_HIGH;
          end
        end
        S_LDIV: begin
          if (div_done) begin
            cur_r   <= div_q[SAMPLE_W-1:0];
            state_r <= S_HIGH;
          end
        end
        S_HIGH: begin
          if (item_r.do_high) begin
            hrs_r[item_r.lead] <= sp_h;
            hds_r[item_r.lead] <= st_h;
            delayed_r          <= hsmp_rd;
            state_r            <= S_HDIV;
          end else begin
            res_r   <= OUT_W'($signed(cur_r));
            state_r <= S_DONE;
          end
        end
        S_HDIV: begin
          if (div_done) begin
            res_r   <= OUT_W'($signed(delayed_r)) - div_q[OUT_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign clear_busy   = clr_act_r;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule

@@ design/multilead_cascaded_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// multilead_cascaded_moving_average_top
// Multi-lead triangular moving-average band-pass filter for ECG samples.
// Input channel: in_valid/in_stall with in_sample (signed 24 bit) and
// in_lead; a transfer happens when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with out_filtered (signed 25 bit),
// one result per input, in input order.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 mode, 1 low-pass length, 2 high-pass length); write only when idle.
// Timing: set mainly by the bit-serial divider, which runs once per stage;
// band pass runs it twice, one stage once, and an out-of-range lead skips it.
// Items are worked on one at a time; a two-entry queue lets the front take
// up to two further samples while one is being worked on.
// Reset: synchronous; afterwards a clearing pass over the 8192 high-ring
// addresses zeroes the ring memories while in_stall stays high.
// A stalled result stays in the output register; the sequencer then holds
// the next item until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilead_cascaded_moving_average_top_defines.svh"
module multilead_cascaded_moving_average_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mcma_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic [mcma_pkg::LEAD_W-1:0]    in_lead,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mcma_pkg::OUT_W-1:0]     out_filtered,
  input  logic                           cfg_we,
  input  logic [mcma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcma_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import mcma_pkg::*;

  logic       clear_busy;
  logic       pop;
  logic       head_valid;
  mcma_item_t head;

  mcma_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_lead(in_lead), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .clear_busy(clear_busy),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  mcma_back u_back (
    .clk(clk), .rst_n(rst_n), .head_valid(head_valid), .head(head),
    .pop(pop), .clear_busy(clear_busy), .out_valid(out_valid),
    .out_stall(out_stall), .out_filtered(out_filtered)
  );

  `MCMA_ASSERT_IMP(a_stall_clear, clear_busy, in_stall, "input taken during clear")
  `MCMA_ASSERT_IMP(a_no_out_clear, clear_busy, !out_valid, "result during clear")
  `MCMA_ASSERT_IMP(a_pop_head, pop, head_valid && !clear_busy, "pop from empty queue")
  `MCMA_ASSERT_NXT(a_one_item, pop, !pop, "two items started back to back")

endmodule
